### sv/lsh_pkg.sv
// lsh_pkg: shared types, codes and helpers of the latency statistics histogram
// used by the front stage, the item queue, the back engine and the top level
package lsh_pkg;

    localparam int ID_W        = 4;
    localparam int WORD_W      = 64;
    localparam int SEL_W       = 7;
    localparam int BKT_W       = 6;
    localparam int NUM_BUCKETS = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [SEL_W-1:0] SEL_COUNT    = 7'd0;
    localparam logic [SEL_W-1:0] SEL_SUM      = 7'd1;
    localparam logic [SEL_W-1:0] SEL_MIN      = 7'd2;
    localparam logic [SEL_W-1:0] SEL_MAX      = 7'd3;
    localparam logic [SEL_W-1:0] SEL_BKT_BASE = 7'd4;
    localparam logic [SEL_W-1:0] SEL_LAST     = 7'd67;

    localparam logic [BKT_W-1:0] BKT_LAST = 6'd63;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RECORD,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLR
    } bk_state_t;

    typedef struct packed {
        op_t               op;
        logic              upd;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] iv;
        logic [BKT_W-1:0]  bidx;
        logic              zero;
        logic [SEL_W-1:0]  sel;
    } q_entry_t;

    typedef struct packed {
        logic [WORD_W-1:0] cnt;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] vmin;
        logic [WORD_W-1:0] vmax;
    } stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic init_busy;
    } bk_status_t;

    localparam stat_t STAT_CLEAR = '{cnt: '0, sum: '0, vmin: '1, vmax: '0};

    function automatic logic [BKT_W-1:0] top_bit(input logic [WORD_W-1:0] v);
        logic [BKT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
            begin
                n = BKT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

### sv/lsh_front.sv
// lsh_front: input stage, accepts a command, computes the interval and its
// bucket and classifies the item for the back engine; depends on lsh_pkg
module lsh_front
    import lsh_pkg::*;
#(
    parameter int NUM_COUNTERS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  logic [ID_W-1:0]   counter_id,
    input  logic [WORD_W-1:0] start_time,
    input  logic [WORD_W-1:0] end_time,
    input  logic [SEL_W-1:0]  word_select,
    input  q_status_t         q_stat,
    input  bk_status_t        bk_stat,
    output logic              busy,
    output logic              push,
    output q_entry_t          push_entry
);

    logic              s_valid_reg;
    logic [1:0]        s_cmd_reg;
    logic [ID_W-1:0]   s_id_reg;
    logic [WORD_W-1:0] s_start_reg;
    logic [WORD_W-1:0] s_end_reg;
    logic [SEL_W-1:0]  s_sel_reg;
    logic              accept;
    logic              id_ok;
    logic [WORD_W-1:0] iv;

    assign busy   = s_valid_reg | q_stat.full | bk_stat.init_busy;
    assign accept = start & ~busy;
    assign push   = s_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_cmd_reg   <= cmd;
            s_id_reg    <= counter_id;
            s_start_reg <= start_time;
            s_end_reg   <= end_time;
            s_sel_reg   <= word_select;
        end
    end

    assign iv    = s_end_reg - s_start_reg;
    assign id_ok = 32'(s_id_reg) < NUM_COUNTERS;

    always_comb
    begin
        push_entry.upd  = id_ok;
        push_entry.id   = s_id_reg;
        push_entry.iv   = iv;
        push_entry.bidx = top_bit(iv);
        push_entry.zero = (iv == '0);
        push_entry.sel  = s_sel_reg;
        unique case (s_cmd_reg)
            CMD_RECORD: push_entry.op = OP_RECORD;
            CMD_READ:   push_entry.op = (id_ok && s_sel_reg <= SEL_LAST) ? OP_READ : OP_NONE;
            CMD_CLEAR:  push_entry.op = id_ok ? OP_CLEAR : OP_NONE;
            default:    push_entry.op = OP_NONE;
        endcase
    end

endmodule

### sv/lsh_queue.sv
// lsh_queue: two-entry item queue between the front stage and the back engine
// depends on lsh_pkg for the entry and status types
module lsh_queue
    import lsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t q_stat
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### sv/lsh_back.sv
// lsh_back: back engine holding the statistics and bucket memories, doing
// read-modify-write per record item, entry clear sweeps and the reset clearing pass
// depends on lsh_pkg
module lsh_back
    import lsh_pkg::*;
#(
    parameter int NUM_COUNTERS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_entry_t          head,
    input  q_status_t         q_stat,
    output logic              pop,
    output bk_status_t        bk_stat,
    output logic              done,
    output logic [WORD_W-1:0] read_data,
    output logic [BKT_W-1:0]  bucket_index,
    output logic              zero_interval
);

    localparam int IDW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int BAW = IDW + BKT_W;
    localparam int BKT_DEPTH = NUM_COUNTERS * NUM_BUCKETS;

    stat_t             stat_mem [NUM_COUNTERS];
    logic [WORD_W-1:0] bkt_mem  [BKT_DEPTH];

    bk_state_t         state_reg, state_next;
    q_entry_t          cur_reg;
    stat_t             stat_rd_reg;
    logic [WORD_W-1:0] bkt_rd_reg;
    logic [BAW-1:0]    sweep_reg, sweep_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [BKT_W-1:0]  bidx_reg, bidx_next;
    logic              zero_reg, zero_next;

    logic [IDW-1:0]    head_id;
    logic [IDW-1:0]    cur_id;
    logic [IDW-1:0]    stat_raddr;
    logic [BAW-1:0]    bkt_raddr;
    logic              stat_we;
    logic [IDW-1:0]    stat_waddr;
    stat_t             stat_wdata;
    logic              bkt_we;
    logic [BAW-1:0]    bkt_waddr;
    logic [WORD_W-1:0] bkt_wdata;
    logic              init_last;
    logic              clr_last;

    assign head_id   = IDW'(head.id);
    assign cur_id    = IDW'(cur_reg.id);
    assign init_last = (sweep_reg == BAW'(BKT_DEPTH - 1));
    assign clr_last  = (sweep_reg[BKT_W-1:0] == BKT_LAST);

    assign stat_raddr = head_id;
    assign bkt_raddr  = (head.op == OP_RECORD) ? {head_id, head.bidx}
                                               : {head_id, BKT_W'(head.sel - SEL_BKT_BASE)};

    assign bk_stat.init_busy = (state_reg == ST_INIT);
    assign pop               = (state_reg == ST_IDLE) && !q_stat.empty;

    assign done          = done_reg;
    assign read_data     = data_reg;
    assign bucket_index  = bidx_reg;
    assign zero_interval = zero_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (cur_reg.op == OP_CLEAR) ? ST_CLR : ST_IDLE;
            end
            ST_CLR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        stat_we    = 1'b0;
        stat_waddr = cur_id;
        stat_wdata = STAT_CLEAR;
        bkt_we     = 1'b0;
        bkt_waddr  = {cur_id, sweep_reg[BKT_W-1:0]};
        bkt_wdata  = '0;
        done_next  = 1'b0;
        data_next  = '0;
        bidx_next  = '0;
        zero_next  = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                sweep_next = sweep_reg + 1'b1;
                stat_we    = 1'b1;
                stat_waddr = sweep_reg[BAW-1:BKT_W];
                bkt_we     = 1'b1;
                bkt_waddr  = sweep_reg;
            end
            ST_IDLE:
            begin
                sweep_next = BAW'(1);
            end
            ST_EXEC:
            begin
                done_next = 1'b1;
                unique case (cur_reg.op)
                    OP_RECORD:
                    begin
                        data_next = cur_reg.iv;
                        bidx_next = cur_reg.zero ? '0 : cur_reg.bidx;
                        zero_next = cur_reg.zero;
                        stat_we   = cur_reg.upd;
                        stat_wdata = stat_rd_reg;
                        stat_wdata.cnt = stat_rd_reg.cnt + 1'b1;
                        if (!cur_reg.zero)
                        begin
                            stat_wdata.sum = stat_rd_reg.sum + cur_reg.iv;
                            if (cur_reg.iv < stat_rd_reg.vmin)
                            begin
                                stat_wdata.vmin = cur_reg.iv;
                            end
                            if (cur_reg.iv > stat_rd_reg.vmax)
                            begin
                                stat_wdata.vmax = cur_reg.iv;
                            end
                        end
                        bkt_we    = cur_reg.upd && !cur_reg.zero;
                        bkt_waddr = {cur_id, cur_reg.bidx};
                        bkt_wdata = bkt_rd_reg + 1'b1;
                    end
                    OP_READ:
                    begin
                        case (cur_reg.sel)
                            SEL_COUNT: data_next = stat_rd_reg.cnt;
                            SEL_SUM:   data_next = stat_rd_reg.sum;
                            SEL_MIN:   data_next = stat_rd_reg.vmin;
                            SEL_MAX:   data_next = stat_rd_reg.vmax;
                            default:   data_next = bkt_rd_reg;
                        endcase
                    end
                    OP_CLEAR:
                    begin
                        stat_we   = 1'b1;
                        bkt_we    = 1'b1;
                        bkt_waddr = {cur_id, BKT_W'(0)};
                    end
                    default:
                    begin
                        data_next = '0;
                    end
                endcase
            end
            ST_CLR:
            begin
                sweep_next = sweep_reg + 1'b1;
                bkt_we     = 1'b1;
            end
            default:
            begin
                sweep_next = sweep_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        bidx_reg <= bidx_next;
        zero_reg <= zero_next;
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
        stat_rd_reg <= stat_mem[stat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_rd_reg <= bkt_mem[bkt_raddr];
    end

endmodule

### sv/latency_stats_histogram_top.sv
// latency_stats_histogram_top: top level of the latency statistics histogram
// instantiates lsh_front, lsh_queue and lsh_back; depends on lsh_pkg
//
// an item is taken when start is high and busy is low; busy is then high in
// the cycle after. record and read items pass through the back engine as a
// memory read in ST_IDLE, then the write-back or result selection in ST_EXEC;
// a clear sweeps the 64 buckets of its entry through the single bucket memory
// write port, bucket 0 in ST_EXEC and the rest in ST_CLR; the two-entry queue
// absorbs this and busy is raised when it is full. a result appears on done,
// read_data, bucket_index and zero_interval for exactly one cycle, in item
// order, after the front stage, queue slot, memory read and result registers;
// the receiver cannot stall it. after reset busy is held high while the
// statistics and bucket memories are cleared, one bucket word per cycle.
module latency_stats_histogram_top
    import lsh_pkg::*;
#(
    parameter int NUM_COUNTERS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  logic [ID_W-1:0]   counter_id,
    input  logic [WORD_W-1:0] start_time,
    input  logic [WORD_W-1:0] end_time,
    input  logic [SEL_W-1:0]  word_select,
    output logic              busy,
    output logic              done,
    output logic [WORD_W-1:0] read_data,
    output logic [BKT_W-1:0]  bucket_index,
    output logic              zero_interval
);

    q_status_t  q_stat;
    bk_status_t bk_stat;
    logic       push;
    logic       pop;
    q_entry_t   push_entry;
    q_entry_t   head;

    lsh_front #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .counter_id  (counter_id),
        .start_time  (start_time),
        .end_time    (end_time),
        .word_select (word_select),
        .q_stat      (q_stat),
        .bk_stat     (bk_stat),
        .busy        (busy),
        .push        (push),
        .push_entry  (push_entry)
    );

    lsh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    lsh_back #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .bk_stat       (bk_stat),
        .done          (done),
        .read_data     (read_data),
        .bucket_index  (bucket_index),
        .zero_interval (zero_interval)
    );

    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> busy)
        else $error("queue full without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a transfer");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.init_busy |-> !done && q_stat.empty)
        else $error("activity during clearing pass");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_interval) |-> (read_data == '0 && bucket_index == '0))
        else $error("zero interval with nonzero result");

endmodule
